// ===== src/wkd_pkg.sv =====
// Shared types and constants for the weighted Kendall distance unit.
package wkd_pkg;
  localparam int RANK_W = 6;
  localparam int VALUES = 64;
  localparam int WGT_W = 16;
  localparam int DIST_W = 27;
  localparam logic [DIST_W-1:0] DIST_MAX = 27'h7FFFFFF;
  localparam int LEN_W = 11;
  localparam int CHUNK = 16;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             err;
    logic             ident;
  } job_t;
endpackage

// ===== src/wkd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/wkd_fifo.sv =====
// Two-entry job queue between the load front end and the compute back end.
module wkd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wkd_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output wkd_pkg::job_t pop_data,
  output logic          empty
);
  import wkd_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue underflow");
endmodule

// ===== src/wkd_front.sv =====
// Front end: accepts requests, fills the stores and classifies each run.
module wkd_front #(
  parameter int MAX_LEN = 64
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [wkd_pkg::RANK_W-1:0]                      rank_p,
  input  logic [wkd_pkg::RANK_W-1:0]                      rank_q,
  input  logic [wkd_pkg::WGT_W-1:0]                       swap_weight,
  input  logic                                            last,
  input  logic                                            identity_mode,
  input  logic                                            run_done,
  output logic                                            st_we,
  output logic [$clog2(MAX_LEN)-1:0]                      st_addr,
  output logic [$clog2(MAX_LEN)-1:0]                      st_pos,
  output logic [wkd_pkg::WGT_W+$clog2(MAX_LEN)-1:0]       st_prefix,
  output logic                                            job_push,
  output wkd_pkg::job_t                                   job_data
);
  import wkd_pkg::*;

  localparam int IDXW = $clog2(MAX_LEN);
  localparam int CNTW = $clog2(MAX_LEN + 1);
  localparam int PW = WGT_W + IDXW;

  logic [CNTW-1:0]   count;
  logic [VALUES-1:0] seen_p;
  logic [VALUES-1:0] seen_q;
  logic [RANK_W-1:0] max_p;
  logic [RANK_W-1:0] max_q;
  logic              err;
  logic              qdup;
  logic [PW-1:0]     wsum;
  logic              busy;

  logic              acc;
  logic              room;
  logic [CNTW-1:0]   count_next;
  logic              err_next;
  logic              qdup_next;
  logic [RANK_W-1:0] max_p_next;
  logic [RANK_W-1:0] max_q_next;

  assign in_ready = !busy;
  assign acc = in_valid && in_ready;
  assign room = (count < CNTW'(MAX_LEN));

  always_comb begin
    count_next = room ? count + CNTW'(1) : count;
    err_next = err || !room || (room && seen_p[rank_p])
               || (room && !identity_mode && seen_q[rank_q]);
    qdup_next = qdup || (room && seen_q[rank_q]);
    max_p_next = (room && rank_p > max_p) ? rank_p : max_p;
    max_q_next = (room && rank_q > max_q) ? rank_q : max_q;
  end

  assign st_we = acc && room;
  assign st_addr = count[IDXW-1:0];
  assign st_pos = count[IDXW-1:0];
  assign st_prefix = wsum;

  assign job_push = acc && last;
  always_comb begin
    job_data.len = LEN_W'(count_next);
    job_data.ident = identity_mode;
    job_data.err = err_next
                   || (LEN_W'(max_p_next) >= LEN_W'(count_next))
                   || (!identity_mode && (qdup_next
                       || (LEN_W'(max_q_next) >= LEN_W'(count_next))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seen_p <= '0;
      seen_q <= '0;
      max_p <= '0;
      max_q <= '0;
      err <= 1'b0;
      qdup <= 1'b0;
      wsum <= '0;
      busy <= 1'b0;
    end else if (acc) begin
      if (last) begin
        count <= '0;
        seen_p <= '0;
        seen_q <= '0;
        max_p <= '0;
        max_q <= '0;
        err <= 1'b0;
        qdup <= 1'b0;
        wsum <= '0;
        busy <= 1'b1;
      end else begin
        count <= count_next;
        err <= err_next;
        qdup <= qdup_next;
        max_p <= max_p_next;
        max_q <= max_q_next;
        if (room) begin
          seen_p[rank_p] <= 1'b1;
          seen_q[rank_q] <= 1'b1;
          wsum <= wsum + PW'(swap_weight);
        end
      end
    end else if (run_done) begin
      busy <= 1'b0;
    end
  end
endmodule

// ===== src/wkd_back.sv =====
// Back end: places each element of p in turn and sums the swap costs.
module wkd_back #(
  parameter int MAX_LEN = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      job_empty,
  input  wkd_pkg::job_t                             job_data,
  output logic                                      job_pop,
  output logic [$clog2(MAX_LEN)-1:0]                p_raddr,
  input  logic [wkd_pkg::RANK_W-1:0]                p_rdata,
  output logic [wkd_pkg::RANK_W-1:0]                q_raddr,
  input  logic [$clog2(MAX_LEN)-1:0]                q_rdata,
  output logic [$clog2(MAX_LEN)-1:0]                pref_raddr,
  input  logic [wkd_pkg::WGT_W+$clog2(MAX_LEN)-1:0] pref_rdata,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [wkd_pkg::DIST_W-1:0]                distance,
  output logic                                      bad_input,
  output logic                                      run_done
);
  import wkd_pkg::*;

  localparam int IDXW = $clog2(MAX_LEN);
  localparam int CNTW = $clog2(MAX_LEN + 1);
  localparam int PW = WGT_W + IDXW;
  localparam int CHUNKS = (MAX_LEN + CHUNK - 1) / CHUNK;
  localparam int CHW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int NB = CHUNKS * CHUNK;
  localparam int NBW = $clog2(NB);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDP = 3'd1;
  localparam logic [2:0] ST_RDQ = 3'd2;
  localparam logic [2:0] ST_QPOS = 3'd3;
  localparam logic [2:0] ST_CNT = 3'd4;
  localparam logic [2:0] ST_RD1 = 3'd5;
  localparam logic [2:0] ST_RD2 = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]        state;
  job_t              job_r;
  logic [CNTW-1:0]   idx;
  logic [RANK_W-1:0] pval;
  logic [IDXW-1:0]   qpos;
  logic [CNTW-1:0]   cnt;
  logic [CHW-1:0]    chunk;
  logic [PW-1:0]     prefpos;
  logic [DIST_W-1:0] acc;
  logic [NB-1:0]     remaining;
  logic              adding;

  logic [CNTW-1:0]   lenc;
  logic [CNTW-1:0]   pos;
  logic [CNTW-1:0]   pc;
  logic [CHUNK-1:0]  bits;
  logic [DIST_W:0]   sum;
  logic              out_free;

  assign lenc = job_r.len[CNTW-1:0];
  assign pos = idx + cnt;
  assign p_raddr = idx[IDXW-1:0];
  assign q_raddr = (state == ST_RDQ) ? p_rdata : pval;
  assign pref_raddr = (state == ST_RD1) ? pos[IDXW-1:0] : idx[IDXW-1:0];
  assign out_free = !out_valid || out_ready;
  assign job_pop = (state == ST_IDLE) && !job_empty;
  assign run_done = (state == ST_DONE) && !adding && out_free;

  always_comb begin
    bits = remaining[chunk*CHUNK +: CHUNK];
    pc = '0;
    for (int j = 0; j < CHUNK; j++) begin
      if (bits[j] && (int'(chunk) * CHUNK + j < int'(qpos))) begin
        pc = pc + CNTW'(1);
      end
    end
    sum = {1'b0, acc} + (DIST_W+1)'(prefpos - pref_rdata);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      adding <= 1'b0;
    end else begin
      if (out_valid && out_ready && !run_done) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            job_r <= job_data;
            idx <= '0;
            acc <= '0;
            adding <= 1'b0;
            for (int b = 0; b < NB; b++) begin
              remaining[b] <= (b < int'(job_data.len));
            end
            state <= job_data.err ? ST_DONE : ST_RDP;
          end
        end
        ST_RDP: begin
          if (adding) begin
            acc <= (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
            remaining[NBW'(qpos)] <= 1'b0;
            adding <= 1'b0;
          end
          state <= ST_RDQ;
        end
        ST_RDQ: begin
          pval <= p_rdata;
          state <= ST_QPOS;
        end
        ST_QPOS: begin
          qpos <= job_r.ident ? IDXW'(pval) : q_rdata;
          cnt <= '0;
          chunk <= '0;
          state <= ST_CNT;
        end
        ST_CNT: begin
          cnt <= cnt + pc;
          if (int'(chunk) == CHUNKS - 1) begin
            state <= ST_RD1;
          end else begin
            chunk <= chunk + CHW'(1);
          end
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          prefpos <= pref_rdata;
          state <= ST_DONE;
          adding <= 1'b1;
        end
        ST_DONE: begin
          if (adding) begin
            acc <= (sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
            remaining[NBW'(qpos)] <= 1'b0;
            adding <= 1'b0;
            idx <= idx + CNTW'(1);
            if (idx + CNTW'(1) != lenc) begin
              state <= ST_RDP;
            end
          end else if (out_free) begin
            out_valid <= 1'b1;
            distance <= job_r.err ? '0 : acc;
            bad_input <= job_r.err;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD1) |-> (pos < lenc))
    else $error("placement position beyond run length");
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (acc <= DIST_MAX))
    else $error("distance accumulator past saturation");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    run_done |=> out_valid)
    else $error("result not presented after run end");
endmodule

// ===== src/weighted_kendall_distance_unit.sv =====
// Weighted Kendall distance unit: top level.
//
// Input channel (in_valid/in_ready): one request per position carrying rank_p,
// rank_q and swap_weight; last marks the final position of a run. Loading
// takes one request per cycle. Output channel (out_valid/out_ready): one
// result per run, distance and bad_input; distance is 0 when bad_input is set.
// cfg_we/cfg_wdata write identity_mode, in which rank_q is ignored and q is
// the identity; write it only between runs.
// After the last request in_ready stays low until the result is in the
// output register. An erroneous run skips the per-position work. Otherwise
// the time per position is set by the chunked count of still unplaced
// elements and the prefix-sum reads. A stalled receiver holds the result;
// the next run is then loaded meanwhile up to its last request. Reset clears
// run state, the queue and the output; the stores need no clearing.
module weighted_kendall_distance_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [wkd_pkg::RANK_W-1:0] rank_p,
  input  logic [wkd_pkg::RANK_W-1:0] rank_q,
  input  logic [wkd_pkg::WGT_W-1:0]  swap_weight,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wkd_pkg::DIST_W-1:0] distance,
  output logic                       bad_input
);
  import wkd_pkg::*;

  localparam int IDXW = $clog2(MAX_LEN);
  localparam int PW = WGT_W + IDXW;

  logic              identity_mode;
  logic              st_we;
  logic [IDXW-1:0]   st_addr;
  logic [IDXW-1:0]   st_pos;
  logic [PW-1:0]     st_prefix;
  logic              job_push;
  job_t              push_data;
  logic              job_full;
  logic              job_pop;
  job_t              pop_data;
  logic              job_empty;
  logic              run_done;
  logic [IDXW-1:0]   p_raddr;
  logic [RANK_W-1:0] p_rdata;
  logic [RANK_W-1:0] q_raddr;
  logic [IDXW-1:0]   q_rdata;
  logic [IDXW-1:0]   pref_raddr;
  logic [PW-1:0]     pref_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_mode <= 1'b0;
    end else if (cfg_we) begin
      identity_mode <= cfg_wdata;
    end
  end

  wkd_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst, .in_valid, .in_ready, .rank_p, .rank_q, .swap_weight, .last,
    .identity_mode, .run_done, .st_we, .st_addr, .st_pos, .st_prefix,
    .job_push, .job_data(push_data)
  );

  wkd_ram #(.WIDTH(RANK_W), .DEPTH(MAX_LEN)) u_p_ram (
    .clk, .we(st_we), .waddr(st_addr), .wdata(rank_p), .raddr(p_raddr),
    .rdata(p_rdata)
  );

  wkd_ram #(.WIDTH(IDXW), .DEPTH(VALUES)) u_qinv_ram (
    .clk, .we(st_we), .waddr(rank_q), .wdata(st_pos), .raddr(q_raddr),
    .rdata(q_rdata)
  );

  wkd_ram #(.WIDTH(PW), .DEPTH(MAX_LEN)) u_pref_ram (
    .clk, .we(st_we), .waddr(st_addr), .wdata(st_prefix), .raddr(pref_raddr),
    .rdata(pref_rdata)
  );

  wkd_fifo u_fifo (
    .clk, .rst, .push(job_push), .push_data, .full(job_full), .pop(job_pop),
    .pop_data, .empty(job_empty)
  );

  wkd_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst, .job_empty, .job_data(pop_data), .job_pop, .p_raddr, .p_rdata,
    .q_raddr, .q_rdata, .pref_raddr, .pref_rdata, .out_valid, .out_ready,
    .distance, .bad_input, .run_done
  );

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("run request with job queue full");
endmodule
